FILE: hdl/rilt_pkg.sv
// rilt_pkg: shared types and constants of the rpc in-flight latency tracker
// used by the interfaces, the front end, the command queue and the back end
`default_nettype none

package rilt_pkg;

    // field widths
    localparam int unsigned ID_W     = 64;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned SIZE_W   = 31;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OUT_CNT_W = 6;

    // request header and ack identifier framing
    localparam logic [SIZE_W-1:0] HDR_BYTES = 31'd12;
    localparam int unsigned ACK_BYTES = 8;
    localparam int unsigned ACK_CNT_W = 3;
    localparam int unsigned ASM_W     = BYTE_W * (ACK_BYTES - 1);
    localparam logic [ACK_CNT_W-1:0] ACK_LAST = 3'(ACK_BYTES - 1);

    // reset value of the size limit register
    localparam logic [SIZE_W-1:0] MAX_BYTES_RESET = 31'd65536;

    // depth of the queue between front and back end
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_ISSUE = 2'd0;
    localparam t_opcode OP_ACK   = 2'd1;
    localparam t_opcode OP_WDONE = 2'd2;
    localparam t_opcode OP_WERR  = 2'd3;

    typedef logic [3:0] t_status;
    localparam t_status ST_ABSORBED = 4'd0;
    localparam t_status ST_ISSUED   = 4'd1;
    localparam t_status ST_ACK_DONE = 4'd2;
    localparam t_status ST_REORDER  = 4'd3;
    localparam t_status ST_UNEXP    = 4'd4;
    localparam t_status ST_WIN_FULL = 4'd5;
    localparam t_status ST_SIZE_REJ = 4'd6;
    localparam t_status ST_WR_DONE  = 4'd7;
    localparam t_status ST_ROLLBACK = 4'd8;

    // command kinds after classification in the front end
    typedef logic [2:0] t_kind;
    localparam t_kind K_ABSORB = 3'd0;
    localparam t_kind K_ISSUE  = 3'd1;
    localparam t_kind K_ACK    = 3'd2;
    localparam t_kind K_WDONE  = 3'd3;
    localparam t_kind K_WERR   = 3'd4;

    // one classified command as it travels through the queue
    typedef struct packed {
        t_kind              kind;
        logic               size_bad;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  now;
        logic [SIZE_W-1:0]  hdr_len;
    } t_cmd;

endpackage

`default_nettype wire

FILE: hdl/rilt_if.sv
// rilt_req_if and rilt_rsp_if: valid/ready channels of the latency tracker
// depends on rilt_pkg for field widths and codes
`default_nettype none

interface rilt_req_if;
    logic                               valid;
    logic                               ready;
    rilt_pkg::t_opcode                  opcode;
    logic [rilt_pkg::ID_W-1:0]          request_id;
    logic [rilt_pkg::TIME_W-1:0]        now_ns;
    logic [rilt_pkg::SIZE_W-1:0]        request_bytes;
    logic [rilt_pkg::BYTE_W-1:0]        ack_byte;

    modport source (output valid, opcode, request_id, now_ns, request_bytes, ack_byte,
                    input ready);
    modport sink   (input valid, opcode, request_id, now_ns, request_bytes, ack_byte,
                    output ready);
endinterface

interface rilt_rsp_if;
    logic                               valid;
    logic                               ready;
    rilt_pkg::t_status                  status;
    logic [rilt_pkg::SIZE_W-1:0]        header_length;
    logic [rilt_pkg::ID_W-1:0]          reported_id;
    logic [rilt_pkg::TIME_W-1:0]        latency_ns;
    logic                               conn_ready;
    logic [rilt_pkg::OUT_CNT_W-1:0]     outstanding_count;

    modport source (output valid, status, header_length, reported_id, latency_ns,
                    conn_ready, outstanding_count, input ready);
    modport sink   (input valid, status, header_length, reported_id, latency_ns,
                    conn_ready, outstanding_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/rilt_front.sv
// rilt_front: accepts requests, assembles ack identifiers and classifies items
// depends on rilt_pkg and rilt_req_if; pushes t_cmd entries into rilt_fifo
`default_nettype none

module rilt_front (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    rilt_req_if.sink                        i_req,
    input  wire  [rilt_pkg::SIZE_W-1:0]     i_max_bytes,
    input  wire                             i_q_full,
    output logic                            o_push,
    output rilt_pkg::t_cmd                  o_cmd
);

    logic [rilt_pkg::ASM_W-1:0]     r_asm;
    logic [rilt_pkg::ACK_CNT_W-1:0] r_cnt;
    logic [rilt_pkg::ASM_W-1:0]     n_asm;
    logic [rilt_pkg::ACK_CNT_W-1:0] n_cnt;
    logic                           accept;

    // take a request whenever the queue has room
    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && !i_q_full;
    assign o_push      = accept;

    // classify the request and advance ack assembly
    always_comb begin
        n_asm          = r_asm;
        n_cnt          = r_cnt;
        o_cmd.kind     = rilt_pkg::K_ABSORB;
        o_cmd.size_bad = (i_req.request_bytes > i_max_bytes)
                      || (i_req.request_bytes < rilt_pkg::HDR_BYTES);
        o_cmd.id       = '0;
        o_cmd.now      = i_req.now_ns;
        o_cmd.hdr_len  = i_req.request_bytes - rilt_pkg::HDR_BYTES;
        unique case (i_req.opcode)
            rilt_pkg::OP_ISSUE: begin
                o_cmd.kind = rilt_pkg::K_ISSUE;
                o_cmd.id   = i_req.request_id;
            end
            rilt_pkg::OP_ACK: begin
                if (r_cnt < rilt_pkg::ACK_LAST) begin
                    o_cmd.kind                   = rilt_pkg::K_ABSORB;
                    n_asm[{r_cnt, 3'b000} +: 8]  = i_req.ack_byte;
                    n_cnt                        = r_cnt + 1'b1;
                end else begin
                    o_cmd.kind = rilt_pkg::K_ACK;
                    o_cmd.id   = {i_req.ack_byte, r_asm};
                    n_asm      = '0;
                    n_cnt      = '0;
                end
            end
            rilt_pkg::OP_WDONE: o_cmd.kind = rilt_pkg::K_WDONE;
            rilt_pkg::OP_WERR:  o_cmd.kind = rilt_pkg::K_WERR;
        endcase
    end

    // ack assembly state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asm <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            r_asm <= n_asm;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rilt_fifo.sv
// rilt_fifo: short command queue between front end and back end
// depends on rilt_pkg for t_cmd and the queue depth
`default_nettype none

module rilt_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire rilt_pkg::t_cmd i_push_data,
    output logic                o_full,
    input  wire                 i_pop,
    output rilt_pkg::t_cmd      o_pop_data,
    output logic                o_empty
);

    rilt_pkg::t_cmd                 r_slot [rilt_pkg::Q_DEPTH];
    logic [rilt_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [rilt_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [rilt_pkg::Q_CNT_W-1:0]   r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full     = (r_count == rilt_pkg::Q_CNT_W'(rilt_pkg::Q_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_slot[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rilt_back.sv
// rilt_back: executes classified commands against the id/time ring
// depends on rilt_pkg and rilt_rsp_if; pops t_cmd entries from rilt_fifo
`default_nettype none

module rilt_back #(
    parameter int unsigned WINDOW = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_empty,
    input  wire rilt_pkg::t_cmd i_cmd,
    output logic                o_pop,
    rilt_rsp_if.source          o_rsp
);

    localparam int unsigned IW = $clog2(WINDOW);
    localparam int unsigned CW = $clog2(WINDOW + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // ring memories
    logic [rilt_pkg::ID_W-1:0]   id_mem   [WINDOW];
    logic [rilt_pkg::TIME_W-1:0] time_mem [WINDOW];

    logic                        r_state;
    logic [IW-1:0]               r_head;
    logic [IW-1:0]               r_tail;
    logic [CW-1:0]               r_cnt;
    logic                        r_wpend;
    rilt_pkg::t_cmd              r_cur;
    logic [rilt_pkg::ID_W-1:0]   r_rd_id;
    logic [rilt_pkg::TIME_W-1:0] r_rd_time;

    logic                        r_out_valid;
    rilt_pkg::t_status           r_status;
    logic [rilt_pkg::SIZE_W-1:0] r_hdr_len;
    logic [rilt_pkg::ID_W-1:0]   r_rep_id;
    logic [rilt_pkg::TIME_W-1:0] r_lat;
    logic                        r_conn_ready;
    logic [rilt_pkg::OUT_CNT_W-1:0] r_out_cnt;

    logic [IW-1:0]               n_head;
    logic [IW-1:0]               n_tail;
    logic [CW-1:0]               n_cnt;
    logic                        n_wpend;
    rilt_pkg::t_status           n_status;
    logic [rilt_pkg::SIZE_W-1:0] n_hdr_len;
    logic [rilt_pkg::ID_W-1:0]   n_rep_id;
    logic [rilt_pkg::TIME_W-1:0] n_lat;
    logic                        n_conn_ready;
    logic [CW+rilt_pkg::OUT_CNT_W-1:0] cnt_ext;

    logic                        out_free;
    logic                        exec;
    logic                        mem_wr;
    logic [IW-1:0]               head_next;
    logic [IW-1:0]               tail_next;
    logic [IW-1:0]               tail_prev;
    logic [IW-1:0]               rd_addr;
    logic                        win_full;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign exec     = (r_state == S_EXEC) && out_free;

    // ring pointer arithmetic
    assign head_next = (r_head == IW'(WINDOW - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == IW'(WINDOW - 1)) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? IW'(WINDOW - 1) : r_tail - 1'b1;
    assign rd_addr   = (i_cmd.kind == rilt_pkg::K_ACK) ? r_head : tail_prev;
    assign win_full  = (r_cnt == CW'(WINDOW));

    // execute the current command
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_cnt        = r_cnt;
        n_wpend      = r_wpend;
        n_status     = rilt_pkg::ST_ABSORBED;
        n_hdr_len    = '0;
        n_rep_id     = '0;
        n_lat        = '0;
        n_conn_ready = 1'b0;
        mem_wr       = 1'b0;
        unique case (r_cur.kind)
            rilt_pkg::K_ISSUE: begin
                n_rep_id = r_cur.id;
                if (win_full) begin
                    n_status = rilt_pkg::ST_WIN_FULL;
                end else if (r_cur.size_bad) begin
                    n_status = rilt_pkg::ST_SIZE_REJ;
                end else begin
                    n_status  = rilt_pkg::ST_ISSUED;
                    n_hdr_len = r_cur.hdr_len;
                    n_tail    = tail_next;
                    n_cnt     = r_cnt + 1'b1;
                    n_wpend   = 1'b1;
                    mem_wr    = 1'b1;
                end
            end
            rilt_pkg::K_ACK: begin
                n_rep_id = r_cur.id;
                if (r_cnt == '0) begin
                    n_status = rilt_pkg::ST_UNEXP;
                end else begin
                    n_status     = (r_rd_id == r_cur.id) ? rilt_pkg::ST_ACK_DONE
                                                         : rilt_pkg::ST_REORDER;
                    n_lat        = r_cur.now - r_rd_time;
                    n_head       = head_next;
                    n_cnt        = r_cnt - 1'b1;
                    n_conn_ready = !r_wpend;
                end
            end
            rilt_pkg::K_WDONE: begin
                n_status     = rilt_pkg::ST_WR_DONE;
                n_wpend      = 1'b0;
                n_conn_ready = (r_cnt < CW'(WINDOW - 1));
            end
            rilt_pkg::K_WERR: begin
                n_status = rilt_pkg::ST_ROLLBACK;
                if (r_cnt != '0) begin
                    n_tail   = tail_prev;
                    n_rep_id = r_rd_id;
                    n_cnt    = r_cnt - 1'b1;
                end
            end
            default: begin
                n_status = rilt_pkg::ST_ABSORBED;
            end
        endcase
        cnt_ext = (CW + rilt_pkg::OUT_CNT_W)'(n_cnt);
    end

    // ring memory write at the tail, registered read for the next command
    always_ff @(posedge i_clk) begin
        if (exec && mem_wr) begin
            id_mem[r_tail]   <= r_cur.id;
            time_mem[r_tail] <= r_cur.now;
        end
        if (o_pop) begin
            r_rd_id   <= id_mem[rd_addr];
            r_rd_time <= time_mem[rd_addr];
            r_cur     <= i_cmd;
        end
    end

    // control state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_cnt       <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (exec) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_cnt   <= n_cnt;
                r_wpend <= n_wpend;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status     <= n_status;
            r_hdr_len    <= n_hdr_len;
            r_rep_id     <= n_rep_id;
            r_lat        <= n_lat;
            r_conn_ready <= n_conn_ready;
            r_out_cnt    <= cnt_ext[rilt_pkg::OUT_CNT_W-1:0];
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.status            = r_status;
    assign o_rsp.header_length     = r_hdr_len;
    assign o_rsp.reported_id       = r_rep_id;
    assign o_rsp.latency_ns        = r_lat;
    assign o_rsp.conn_ready        = r_conn_ready;
    assign o_rsp.outstanding_count = r_out_cnt;

    // occupancy never exceeds the window
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(WINDOW))
        else $error("in-flight count above window");

    // empty or full ring has head and tail meeting
    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == CW'(WINDOW)) |-> (r_head == r_tail))
        else $error("ring pointers disagree with count");

    // an executed command always lands in the result register
    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_out_valid)
        else $error("executed command produced no result");

    // a pop is never taken while a command is still executing
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !out_free) |=> (r_state == S_EXEC && $stable(r_cnt)))
        else $error("command state changed under output stall");

endmodule

`default_nettype wire

FILE: hdl/rpc_inflight_latency_tracker.sv
// Tracks requests in flight on one connection in a ring of WINDOW identifier and
// issue-time entries and reports header length, ack latency and readiness, one
// result per request. The front end takes a request in any cycle the two-entry
// command queue has room, assembling ack bytes and checking sizes as it goes; the
// back end handles one command at a time: it reads the ring memory as it pops a
// command, then updates the ring state and loads the output register, waiting
// while that register still holds a result not yet taken. No clearing pass is
// needed after reset. The size limit register is written through
// i_cfg_we/i_cfg_wdata; the user must write it only while the block is idle,
// and the block itself does not enforce this.
// depends on rilt_pkg, rilt_if, rilt_front, rilt_fifo and rilt_back
`default_nettype none

module rpc_inflight_latency_tracker #(
    parameter int unsigned WINDOW = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [rilt_pkg::SIZE_W-1:0]     i_cfg_wdata,
    rilt_req_if.sink                        i_req,
    rilt_rsp_if.source                      o_rsp
);

    logic [rilt_pkg::SIZE_W-1:0] r_max_bytes;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_push;
    logic                        q_pop;
    rilt_pkg::t_cmd              q_in;
    rilt_pkg::t_cmd              q_out;

    // size limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= rilt_pkg::MAX_BYTES_RESET;
        end else if (i_cfg_we) begin
            r_max_bytes <= i_cfg_wdata;
        end
    end

    // classification front end
    rilt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_max_bytes (r_max_bytes),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    // command queue
    rilt_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_out),
        .o_empty     (q_empty)
    );

    // ring back end
    rilt_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (q_out),
        .o_pop     (q_pop),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire
